// File: rtl/regulator_covariance_engine_core_assert.svh
// ----------------------------------------------------------------------------
// regulator covariance engine assertion macros
// concurrent checks clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef REGULATOR_COVARIANCE_ENGINE_CORE_ASSERT_SVH
`define REGULATOR_COVARIANCE_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define RCE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rce check failed");
`define RCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rce check failed");
`else
`define RCE_ASSERT_IMPL(lbl, ante, cons)
`define RCE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/rce_pkg.sv
// ----------------------------------------------------------------------------
// rce_pkg
// shared types and constants of the regulator covariance engine
// ----------------------------------------------------------------------------
`default_nettype none

package rce_pkg;

    localparam int DEF_MAX_VARS    = 64;
    localparam int DEF_MAX_SAMPLES = 256;

    localparam int DATA_W     = 32;
    localparam int CFG_VARS_W = 7;
    localparam int CFG_SMPS_W = 9;

    localparam logic [31:0] MINUS_ONE_Q16 = 32'hFFFF_0000;
    localparam logic [31:0] EPS_Q32       = 32'd4294967;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_MARK    = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_VARS    = 1'b0,
        REG_SAMPLES = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic valid;
        logic clear;
        logic sum_mode;
        logic add_eps;
    } mac_ctl_t;

endpackage

`default_nettype wire

// File: rtl/rce_mac.sv
// ----------------------------------------------------------------------------
// rce_mac
// deviation, multiply and wide accumulate unit shared by all sums
// ----------------------------------------------------------------------------
`default_nettype none

module rce_mac #(
    parameter int ACCW = 75
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire rce_pkg::mac_ctl_t      ctl,
    input  wire logic [31:0]            x,
    input  wire logic [31:0]            y,
    input  wire logic [31:0]            mean_a,
    input  wire logic [31:0]            mean_b,
    output logic signed [ACCW-1:0]      acc,
    output logic                        busy
);
    import rce_pkg::*;

    logic               v1_reg;
    logic               v2_reg;
    logic signed [32:0] da_reg;
    logic signed [32:0] db_reg;
    logic signed [65:0] prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [32:0] da_next;
    logic signed [32:0] db_next;

    always_comb
    begin
        da_next = {x[31], x} - (ctl.sum_mode ? 33'sd0 : {mean_a[31], mean_a});
        db_next = ctl.sum_mode ? 33'sd1 : ({y[31], y} - {mean_b[31], mean_b});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        da_reg   <= da_next;
        db_reg   <= db_next;
        prod_reg <= da_reg * db_reg;
        if (ctl.clear)
        begin
            acc_reg <= ctl.add_eps ? ACCW'(EPS_Q32) : '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACCW'(prod_reg);
        end
    end

    assign acc  = acc_reg;
    assign busy = v1_reg | v2_reg;

endmodule

`default_nettype wire

// File: rtl/rce_div.sv
// ----------------------------------------------------------------------------
// rce_div
// serial restoring divider, truncates toward zero, saturates to 32 bits
// ----------------------------------------------------------------------------
`default_nettype none

`include "regulator_covariance_engine_core_assert.svh"

module rce_div #(
    parameter int ACCW = 75,
    parameter int DVW  = 25
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic signed [ACCW-1:0] dividend,
    input  wire logic [DVW-1:0]         divisor,
    output logic                        busy,
    output logic                        done,
    output logic [31:0]                 result
);
    import rce_pkg::*;

    localparam int CW = $clog2(ACCW);

    logic            busy_reg;
    logic            fin_reg;
    logic            done_reg;
    logic            neg_reg;
    logic [CW-1:0]   cnt_reg;
    logic [ACCW-1:0] q_reg;
    logic [DVW-1:0]  rem_reg;
    logic [DVW-1:0]  d_reg;
    logic [31:0]     res_reg;

    logic [DVW:0]    rem_sh;
    logic            ge;
    logic [DVW:0]    rem_sub;
    logic            hi;
    logic [31:0]     sat;

    always_comb
    begin
        rem_sh  = {rem_reg, q_reg[ACCW-1]};
        ge      = rem_sh >= {1'b0, d_reg};
        rem_sub = rem_sh - {1'b0, d_reg};
        hi      = |q_reg[ACCW-1:32];
        if (neg_reg)
        begin
            sat = (hi || q_reg[31:0] > 32'h8000_0000) ? 32'h8000_0000 : (~q_reg[31:0] + 32'd1);
        end
        else
        begin
            sat = (hi || q_reg[31]) ? 32'h7FFF_FFFF : q_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg  <= busy_reg && !start && (cnt_reg == CW'(ACCW - 1));
            done_reg <= fin_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(ACCW - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[ACCW-1];
            q_reg   <= dividend[ACCW-1] ? ACCW'(-dividend) : ACCW'(dividend);
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[ACCW-2:0], ge};
            rem_reg <= ge ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
        end
        if (fin_reg)
        begin
            res_reg <= sat;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = res_reg;

    `RCE_ASSERT_IMPL(a_start_idle, start, !busy_reg && !fin_reg)
    `RCE_ASSERT_NEXT(a_start_busy, start, busy_reg)
    `RCE_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg)

endmodule

`default_nettype wire

// File: rtl/regulator_covariance_engine_core.sv
// ----------------------------------------------------------------------------
// regulator_covariance_engine_core
// sample covariance matrix with regulator-only cross terms, Q16.16
// ----------------------------------------------------------------------------
// usage
//   s_* stream carries commands: tuser holds the command, tdata the operands.
//   load and mark transactions give no result.
//   a read transaction gives one result (entry and row mean) through the
//   S_RD and S_OUT states; s_tready is low while the engine is in them.
//   a compute transaction clears the matrix, then runs one job per mean,
//   diagonal and regulator entry; each job streams its samples through the
//   shared multiply-accumulate unit, then the divider, which gives one
//   quotient bit per cycle. s_tready stays low until it is done, then one
//   result with m_tuser set acknowledges it.
//   m_* stream holds a result in an output register; while the receiver
//   stalls, a finished read or compute waits and no new command is taken.
//   after reset all matrix entries read as -1.0 and all means as zero;
//   sample storage holds no defined value until loaded.
//   apb port: register 0 variable count at 0x0, register 1 sample count at 0x4.
// ----------------------------------------------------------------------------
`default_nettype none

`include "regulator_covariance_engine_core_assert.svh"

module regulator_covariance_engine_core #(
    parameter int MAX_VARS    = rce_pkg::DEF_MAX_VARS,
    parameter int MAX_SAMPLES = rce_pkg::DEF_MAX_SAMPLES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // var_index[5:0], sample_index[13:6], sample_value[45:14], reg_mark[46],
    // col_index[52:47], zero fill
    input  wire logic [55:0] s_tdata,
    // command[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // cov_value[31:0], mean_value[63:32]
    output logic [63:0]      m_tdata,
    // is_done[0]
    output logic [0:0]       m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rce_pkg::*;

    localparam int VW   = $clog2(MAX_VARS);
    localparam int SW   = $clog2(MAX_SAMPLES);
    localparam int VCW  = $clog2(MAX_VARS + 1);
    localparam int NW   = $clog2(MAX_SAMPLES + 1);
    localparam int ACCW = 67 + SW;
    localparam int DVW  = NW + 16;
    localparam int STD  = 1 << (VW + SW);
    localparam int CVD  = 1 << (2 * VW);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CLR, S_SEL, S_JOB, S_FEED, S_DRAIN, S_DIV, S_WB, S_WB2, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_MEAN, PH_DIAG, PH_CROSS
    } phase_t;

    logic [31:0] store_mem [STD];
    logic [31:0] mean_mem  [MAX_VARS];
    logic [31:0] cov_mem   [CVD];

    state_t              state_reg;
    phase_t              phase_reg;
    logic [CFG_VARS_W-1:0] vars_reg;
    logic [CFG_SMPS_W-1:0] smps_reg;
    logic [MAX_VARS-1:0] marks_reg;
    logic                computed_reg;
    logic [VCW-1:0]      vcnt_reg;
    logic [NW-1:0]       n_reg;
    logic [VCW-1:0]      vi_reg;
    logic [VCW-1:0]      vj_reg;
    logic [NW-1:0]       k_reg;
    logic [2*VW-1:0]     clr_reg;
    logic                feed_v_reg;
    logic                rd_ok_reg;
    logic [31:0]         pend_cov_reg;
    logic [31:0]         pend_mean_reg;
    logic                pend_done_reg;
    logic                out_v_reg;
    logic [31:0]         out_cov_reg;
    logic [31:0]         out_mean_reg;
    logic                out_done_reg;

    logic [31:0]         store_a_q;
    logic [31:0]         store_b_q;
    logic [31:0]         mean_a_q;
    logic [31:0]         mean_b_q;
    logic [31:0]         cov_q;

    cmd_t                cmd;
    logic [5:0]          in_var;
    logic [7:0]          in_smp;
    logic [31:0]         in_val;
    logic                in_mark;
    logic [5:0]          in_col;
    logic                accept;
    logic                var_ok;
    logic                smp_ok;
    logic                col_ok;
    logic [31:0]         vc_w;
    logic [31:0]         nc_w;

    logic                st_we;
    logic [VW+SW-1:0]    st_waddr;
    logic [VW+SW-1:0]    st_raddr_a;
    logic [VW+SW-1:0]    st_raddr_b;
    logic [VW-1:0]       mean_raddr_a;
    logic                mean_we;
    logic [VW-1:0]       mean_waddr;
    logic [31:0]         mean_wdata;
    logic                cov_we;
    logic [2*VW-1:0]     cov_waddr;
    logic [31:0]         cov_wdata;
    logic [2*VW-1:0]     cov_raddr;

    mac_ctl_t            mac_ctl;
    logic signed [ACCW-1:0] mac_acc;
    logic                mac_busy;
    logic                div_start;
    logic                div_busy;
    logic                div_done;
    logic [31:0]         div_res;
    logic [DVW-1:0]      divisor;
    logic [NW-1:0]       n_m1;
    logic                cfg_we;

    assign cmd     = cmd_t'(s_tuser);
    assign in_var  = s_tdata[5:0];
    assign in_smp  = s_tdata[13:6];
    assign in_val  = s_tdata[45:14];
    assign in_mark = s_tdata[46];
    assign in_col  = s_tdata[52:47];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign var_ok   = 32'(in_var) < 32'(MAX_VARS);
    assign smp_ok   = 32'(in_smp) < 32'(MAX_SAMPLES);
    assign col_ok   = 32'(in_col) < 32'(MAX_VARS);

    // apb registers
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (reg_idx_t'(paddr[2]) == REG_SAMPLES) ? 32'(smps_reg) : 32'(vars_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vars_reg <= CFG_VARS_W'(64);
            smps_reg <= CFG_SMPS_W'(256);
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(paddr[2]))
                REG_VARS:    vars_reg <= pwdata[CFG_VARS_W-1:0];
                REG_SAMPLES: smps_reg <= pwdata[CFG_SMPS_W-1:0];
                default:     vars_reg <= vars_reg;
            endcase
        end
    end

    // clamped counts
    always_comb
    begin
        vc_w = 32'(vars_reg);
        nc_w = 32'(smps_reg);
        if (vc_w == 32'd0)
        begin
            vc_w = 32'd1;
        end
        else if (vc_w > 32'(MAX_VARS))
        begin
            vc_w = 32'(MAX_VARS);
        end
        if (nc_w < 32'd2)
        begin
            nc_w = 32'd2;
        end
        else if (nc_w > 32'(MAX_SAMPLES))
        begin
            nc_w = 32'(MAX_SAMPLES);
        end
    end

    // memory ports
    always_comb
    begin
        st_we        = accept && (cmd == CMD_LOAD) && var_ok && smp_ok;
        st_waddr     = {VW'(in_var), SW'(in_smp)};
        st_raddr_a   = {VW'(vi_reg), SW'(k_reg)};
        st_raddr_b   = {VW'(vj_reg), SW'(k_reg)};
        mean_raddr_a = (state_reg == S_IDLE) ? VW'(in_var) : VW'(vi_reg);
        cov_raddr    = {VW'(in_var), VW'(in_col)};
        mean_we      = 1'b0;
        mean_waddr   = VW'(vi_reg);
        mean_wdata   = div_res;
        cov_we       = 1'b0;
        cov_waddr    = {VW'(vi_reg), VW'(vj_reg)};
        cov_wdata    = div_res;
        case (state_reg)
            S_CLR:
            begin
                mean_we    = 1'b1;
                mean_waddr = clr_reg[VW-1:0];
                mean_wdata = '0;
                cov_we     = 1'b1;
                cov_waddr  = clr_reg;
                cov_wdata  = MINUS_ONE_Q16;
            end
            S_WB:
            begin
                mean_we = (phase_reg == PH_MEAN);
                cov_we  = (phase_reg != PH_MEAN);
            end
            S_WB2:
            begin
                cov_we    = 1'b1;
                cov_waddr = {VW'(vj_reg), VW'(vi_reg)};
            end
            default:
            begin
                cov_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= in_val;
        end
        store_a_q <= store_mem[st_raddr_a];
        store_b_q <= store_mem[st_raddr_b];
    end

    always_ff @(posedge clk)
    begin
        if (mean_we)
        begin
            mean_mem[mean_waddr] <= mean_wdata;
        end
        mean_a_q <= mean_mem[mean_raddr_a];
        mean_b_q <= mean_mem[VW'(vj_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (cov_we)
        begin
            cov_mem[cov_waddr] <= cov_wdata;
        end
        cov_q <= cov_mem[cov_raddr];
    end

    // shared arithmetic
    assign n_m1    = n_reg - NW'(1);
    assign divisor = (phase_reg == PH_MEAN) ? DVW'(n_reg) : {n_m1, 16'h0000};

    always_comb
    begin
        mac_ctl.valid    = feed_v_reg;
        mac_ctl.clear    = (state_reg == S_JOB);
        mac_ctl.sum_mode = (phase_reg == PH_MEAN);
        mac_ctl.add_eps  = (phase_reg == PH_DIAG);
        div_start        = (state_reg == S_DRAIN) && !feed_v_reg && !mac_busy;
    end

    rce_mac #(
        .ACCW (ACCW)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .x      (store_a_q),
        .y      (store_b_q),
        .mean_a (mean_a_q),
        .mean_b (mean_b_q),
        .acc    (mac_acc),
        .busy   (mac_busy)
    );

    rce_div #(
        .ACCW (ACCW),
        .DVW  (DVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mac_acc),
        .divisor  (divisor),
        .busy     (div_busy),
        .done     (div_done),
        .result   (div_res)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_MEAN;
            marks_reg     <= '0;
            computed_reg  <= 1'b0;
            vcnt_reg      <= '0;
            n_reg         <= '0;
            vi_reg        <= '0;
            vj_reg        <= '0;
            k_reg         <= '0;
            clr_reg       <= '0;
            feed_v_reg    <= 1'b0;
            rd_ok_reg     <= 1'b0;
            pend_cov_reg  <= '0;
            pend_mean_reg <= '0;
            pend_done_reg <= 1'b0;
            out_v_reg     <= 1'b0;
            out_cov_reg   <= '0;
            out_mean_reg  <= '0;
            out_done_reg  <= 1'b0;
        end
        else
        begin
            feed_v_reg <= (state_reg == S_FEED);
            if ((state_reg == S_OUT) && (!out_v_reg || m_tready))
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd)
                            CMD_MARK:
                            begin
                                if (var_ok)
                                begin
                                    marks_reg[VW'(in_var)] <= in_mark;
                                end
                            end
                            CMD_COMPUTE:
                            begin
                                vcnt_reg  <= VCW'(vc_w);
                                n_reg     <= NW'(nc_w);
                                clr_reg   <= '0;
                                state_reg <= S_CLR;
                            end
                            CMD_READ:
                            begin
                                rd_ok_reg <= var_ok && col_ok;
                                state_reg <= S_RD;
                            end
                            default:
                            begin
                                rd_ok_reg <= rd_ok_reg;
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    pend_cov_reg  <= (rd_ok_reg && computed_reg) ? cov_q : MINUS_ONE_Q16;
                    pend_mean_reg <= (rd_ok_reg && computed_reg) ? mean_a_q : 32'd0;
                    pend_done_reg <= 1'b0;
                    state_reg     <= S_OUT;
                end
                S_CLR:
                begin
                    clr_reg <= clr_reg + (2*VW)'(1);
                    if (clr_reg == '1)
                    begin
                        phase_reg <= PH_MEAN;
                        vi_reg    <= '0;
                        vj_reg    <= '0;
                        state_reg <= S_SEL;
                    end
                end
                S_SEL:
                begin
                    case (phase_reg)
                        PH_MEAN:
                        begin
                            if (vi_reg == vcnt_reg)
                            begin
                                phase_reg <= PH_DIAG;
                                vi_reg    <= '0;
                            end
                            else
                            begin
                                state_reg <= S_JOB;
                            end
                        end
                        PH_DIAG:
                        begin
                            if (vi_reg == vcnt_reg)
                            begin
                                phase_reg <= PH_CROSS;
                                vi_reg    <= '0;
                                vj_reg    <= '0;
                            end
                            else
                            begin
                                vj_reg    <= vi_reg;
                                state_reg <= S_JOB;
                            end
                        end
                        default:
                        begin
                            if (vi_reg == vcnt_reg)
                            begin
                                computed_reg  <= 1'b1;
                                pend_cov_reg  <= '0;
                                pend_mean_reg <= '0;
                                pend_done_reg <= 1'b1;
                                state_reg     <= S_OUT;
                            end
                            else if (!marks_reg[VW'(vi_reg)] || vj_reg == vcnt_reg)
                            begin
                                vi_reg <= vi_reg + VCW'(1);
                                vj_reg <= '0;
                            end
                            else if (vj_reg == vi_reg)
                            begin
                                vj_reg <= vj_reg + VCW'(1);
                            end
                            else
                            begin
                                state_reg <= S_JOB;
                            end
                        end
                    endcase
                end
                S_JOB:
                begin
                    k_reg     <= '0;
                    state_reg <= S_FEED;
                end
                S_FEED:
                begin
                    k_reg <= k_reg + NW'(1);
                    if (k_reg == n_m1)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (div_start)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    if (phase_reg == PH_CROSS)
                    begin
                        state_reg <= S_WB2;
                    end
                    else
                    begin
                        vi_reg    <= vi_reg + VCW'(1);
                        state_reg <= S_SEL;
                    end
                end
                S_WB2:
                begin
                    vj_reg    <= vj_reg + VCW'(1);
                    state_reg <= S_SEL;
                end
                S_OUT:
                begin
                    if (!out_v_reg || m_tready)
                    begin
                        out_cov_reg  <= pend_cov_reg;
                        out_mean_reg <= pend_mean_reg;
                        out_done_reg <= pend_done_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_mean_reg, out_cov_reg};
    assign m_tuser  = out_done_reg;

    `RCE_ASSERT_IMPL(a_done_after_compute, m_tvalid && m_tuser[0], computed_reg)
    `RCE_ASSERT_NEXT(a_computed_holds, computed_reg, computed_reg)
    `RCE_ASSERT_IMPL(a_div_mac_exclusive, div_busy, !mac_busy && !feed_v_reg)

endmodule

`default_nettype wire

// File: sim/rce_checker.sv
// ----------------------------------------------------------------------------
// rce_checker
// watches the command, result and register ports of the covariance engine,
// predicts every result from its own copy of the state and compares
// ----------------------------------------------------------------------------
`default_nettype none

module rce_checker
    import rce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [55:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,
    input  wire logic [0:0]  m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [31:0] cov;
        logic [31:0] mean;
        logic        done;
    } cov_result_t;

    logic [31:0] sample_mem [0:DEF_MAX_VARS*DEF_MAX_SAMPLES-1];
    logic        reg_marks  [0:DEF_MAX_VARS-1];
    logic [31:0] var_means  [0:DEF_MAX_VARS-1];
    logic [31:0] cov_mat    [0:DEF_MAX_VARS*DEF_MAX_VARS-1];
    logic [6:0]  vars_cfg;
    logic [8:0]  smps_cfg;
    cov_result_t expected_results [$];

    initial
    begin
        foreach (sample_mem[i]) sample_mem[i] = '0;
        foreach (reg_marks[i]) reg_marks[i] = 1'b0;
        foreach (var_means[i]) var_means[i] = '0;
        foreach (cov_mat[i]) cov_mat[i] = MINUS_ONE_Q16;
        vars_cfg   = 7'd64;
        smps_cfg   = 9'd256;
    end

    function automatic void add_expected(cov_result_t r);
        expected_results = {expected_results, r};
    endfunction

    function automatic logic [31:0] cov_term(int a, int b, int n, bit diag);
        logic signed [127:0] acc, pa, pb, den, q;
        logic signed [127:0] hi_lim, lo_lim;
        longint ma, mb;
        begin
            hi_lim = 128'sd2147483647;
            lo_lim = -128'sd2147483648;
            ma = longint'($signed(var_means[a]));
            mb = longint'($signed(var_means[b]));
            acc = diag ? 128'sd4294967 : 128'sd0;
            for (int k = 0; k < n; k++)
            begin
                pa = 128'(longint'($signed(sample_mem[a*DEF_MAX_SAMPLES+k])) - ma);
                pb = 128'(longint'($signed(sample_mem[b*DEF_MAX_SAMPLES+k])) - mb);
                acc = acc + pa * pb;
            end
            den = 128'((n - 1) * 65536);
            q = acc / den;
            if (q > hi_lim)
                return 32'h7FFF_FFFF;
            else if (q < lo_lim)
                return 32'h8000_0000;
            return q[31:0];
        end
    endfunction

    task automatic build_matrix();
        int vc, n;
        longint sum;
        logic [31:0] c;
        begin
            vc = int'(vars_cfg);
            n  = int'(smps_cfg);
            if (vc < 1) vc = 1;
            if (vc > DEF_MAX_VARS) vc = DEF_MAX_VARS;
            if (n < 2) n = 2;
            if (n > DEF_MAX_SAMPLES) n = DEF_MAX_SAMPLES;
            foreach (cov_mat[i]) cov_mat[i] = MINUS_ONE_Q16;
            for (int i = 0; i < DEF_MAX_VARS; i++)
            begin
                sum = 0;
                if (i < vc)
                begin
                    for (int k = 0; k < n; k++)
                        sum += longint'($signed(sample_mem[i*DEF_MAX_SAMPLES+k]));
                    sum = sum / longint'(n);
                end
                var_means[i] = sum[31:0];
            end
            for (int i = 0; i < vc; i++)
                cov_mat[i*DEF_MAX_VARS+i] = cov_term(i, i, n, 1'b1);
            for (int i = 0; i < vc; i++)
            begin
                if (reg_marks[i])
                begin
                    for (int j = 0; j < vc; j++)
                    begin
                        if (j != i)
                        begin
                            c = cov_term(i, j, n, 1'b0);
                            cov_mat[i*DEF_MAX_VARS+j] = c;
                            cov_mat[j*DEF_MAX_VARS+i] = c;
                        end
                    end
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        cov_result_t res, got;
        logic [5:0]  vi, ci;
        logic [7:0]  si;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_VARS, 2'b00})
                    vars_cfg = pwdata[6:0];
                else if (paddr == {REG_SAMPLES, 2'b00})
                    smps_cfg = pwdata[8:0];
            end
            if (m_tvalid && m_tready)
            begin
                got = '{cov: m_tdata[31:0], mean: m_tdata[63:32], done: m_tuser[0]};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, actual %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    res = expected_results.pop_front();
                    if (got.cov !== res.cov)
                    begin
                        $display("%0t: cov_value expected %h actual %h", $time, res.cov, got.cov);
                        fail_count++;
                    end
                    if (got.mean !== res.mean)
                    begin
                        $display("%0t: mean_value expected %h actual %h",
                                 $time, res.mean, got.mean);
                        fail_count++;
                    end
                    if (got.done !== res.done)
                    begin
                        $display("%0t: is_done expected %b actual %b",
                                 $time, res.done, got.done);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                vi = s_tdata[5:0];
                si = s_tdata[13:6];
                ci = s_tdata[52:47];
                case (cmd_t'(s_tuser))
                    CMD_LOAD:
                        sample_mem[vi*DEF_MAX_SAMPLES+si] = s_tdata[45:14];
                    CMD_MARK:
                        reg_marks[vi] = s_tdata[46];
                    CMD_COMPUTE:
                    begin
                        build_matrix();
                        add_expected('{cov: '0, mean: '0, done: 1'b1});
                    end
                    default:
                        add_expected('{cov: cov_mat[vi*DEF_MAX_VARS+ci],
                                       mean: var_means[vi], done: 1'b0});
                endcase
            end
            pending <= expected_results.size();
        end
    end

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the regulator covariance engine: directed extremes, then
// phases of register settings with loads, marks, reads and computes
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import rce_pkg::*;

    localparam int STALL_LIMIT = 600000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // var_index[5:0], sample_index[13:6], sample_value[45:14], reg_mark[46],
    // col_index[52:47], zero fill
    logic [55:0] s_tdata = '0;
    // command[1:0]
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // cov_value[31:0], mean_value[63:32]
    logic [63:0] m_tdata;
    // is_done[0]
    logic [0:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;

    bit          loaded [0:DEF_MAX_VARS*DEF_MAX_SAMPLES-1];
    bit          marked [0:DEF_MAX_VARS-1];
    int          mark_total;
    int          item_total;
    int          burst_left;
    int          eff_vars, eff_smps;

    regulator_covariance_engine_core uut (.*);

    rce_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int seg, mode;
        seg = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_done <= 1'b1;
            end
            else
            begin
                if (seg == 0)
                begin
                    seg  = $urandom_range(20, 200);
                    mode = $urandom_range(0, 2);
                end
                seg--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic issue(cmd_t cmd, int vi, int si, logic [31:0] val,
                         logic mk, int ci);
        int gap;
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            s_tvalid <= 1'b1;
            s_tuser  <= cmd;
            s_tdata  <= {3'b000, 6'(ci), mk, val, 8'(si), 6'(vi)};
            do @(posedge clk); while (!s_tready);
            item_total++;
            if (cmd == CMD_LOAD)
                loaded[vi*DEF_MAX_SAMPLES+si] = 1'b1;
            if (cmd == CMD_MARK)
            begin
                if (mk && !marked[vi]) mark_total++;
                if (!mk && marked[vi]) mark_total--;
                marked[vi] = mk;
            end
        end
    endtask

    task automatic load_value(int vi, int si, logic [31:0] val);
        issue(CMD_LOAD, vi, si, val, 1'($urandom_range(0, 1)), $urandom);
    endtask

    task automatic read_entry(int vi, int ci);
        issue(CMD_READ, vi, $urandom, $urandom, 1'($urandom_range(0, 1)), ci);
    endtask

    task automatic set_mark(int vi, logic mk);
        if (mk && !marked[vi] && mark_total >= 6)
            mk = 1'b0;
        issue(CMD_MARK, vi, $urandom, $urandom, mk, $urandom);
    endtask

    // every sample a compute reads must have been loaded
    task automatic compute_all();
        for (int v = 0; v < eff_vars; v++)
            for (int k = 0; k < eff_smps; k++)
                if (!loaded[v*DEF_MAX_SAMPLES+k])
                    load_value(v, k, pick_value());
        issue(CMD_COMPUTE, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)), $urandom);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(int vars, int smps);
        apb_write(REG_VARS, vars);
        apb_write(REG_SAMPLES, smps);
        eff_vars = (vars & 127) < 1 ? 1 : ((vars & 127) > 64 ? 64 : (vars & 127));
        eff_smps = (smps & 511) < 2 ? 2 : ((smps & 511) > 256 ? 256 : (smps & 511));
    endtask

    function automatic int near_var();
        return ($urandom_range(0, 3) != 0) ? $urandom_range(0, eff_vars - 1)
                                           : $urandom_range(0, 63);
    endfunction

    initial
    begin
        int p, r, nrand;
        foreach (loaded[i]) loaded[i] = 1'b0;
        foreach (marked[i]) marked[i] = 1'b0;
        mark_total = 0;
        item_total = 0;
        burst_left = 0;
        eff_vars = 64;
        eff_smps = 256;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state, saturation both ways, regulator beyond the variable count
        read_entry(0, 0);
        read_entry(63, 63);
        wait_idle();
        configure(2, 2);
        load_value(0, 0, 32'h7FFF_FFFF);
        load_value(0, 1, 32'h8000_0000);
        load_value(1, 0, 32'h8000_0000);
        load_value(1, 1, 32'h7FFF_FFFF);
        load_value(63, 255, 32'h1234_5678);
        set_mark(0, 1'b1);
        set_mark(63, 1'b1);
        compute_all();
        read_entry(0, 0);
        read_entry(0, 1);
        read_entry(1, 0);
        read_entry(1, 1);
        read_entry(2, 2);
        read_entry(63, 63);
        set_mark(63, 1'b0);
        set_mark(0, 1'b0);
        compute_all();
        read_entry(0, 1);

        p = 0;
        while ((p < 8 || item_total < 1100) && p < 40)
        begin
            wait_idle();
            case (p)
                0: configure(64, 2);
                1: configure(1, 511);
                2: configure(0, 1);
                3: configure(127, 3);
                5: configure(1, 256);
                default: configure($urandom_range(1, 8), $urandom_range(2, 12));
            endcase
            nrand = (eff_vars * eff_smps > 64) ? 40 : 70;
            repeat (nrand)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    load_value(($urandom_range(0, 3) != 0) ? $urandom_range(0, eff_vars - 1)
                                                            : $urandom_range(0, 63),
                               ($urandom_range(0, 3) != 0) ? $urandom_range(0, eff_smps - 1)
                                                            : $urandom_range(0, 255),
                               pick_value());
                else if (r < 62)
                    set_mark(near_var(), 1'($urandom_range(0, 1)));
                else if (r < 95 || eff_vars > 8)
                    read_entry(near_var(), near_var());
                else
                    compute_all();
            end
            compute_all();
            if (p == 4)
                hold_req <= 1'b1;
            repeat ((p == 4) ? 60 : 12)
                read_entry(near_var(), near_var());
            p++;
        end

        wait_idle();
        repeat (32) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
